// File: hw/rtl/gpx_pkg.sv
// gpx_pkg: item types, register addresses and reset values for the gpio expander
// no dependencies; imported by gpx_core and gpio_expander_registers

package gpx_pkg;

    localparam int NUM_PINS = 16;

    // operation codes
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    // register map
    localparam logic [6:0] ADDR_IN0    = 7'h00;
    localparam logic [6:0] ADDR_IN1    = 7'h01;
    localparam logic [6:0] ADDR_OUT0   = 7'h02;
    localparam logic [6:0] ADDR_OUT1   = 7'h03;
    localparam logic [6:0] ADDR_DIR0   = 7'h04;
    localparam logic [6:0] ADDR_DIR1   = 7'h05;
    localparam logic [6:0] ADDR_MASK0  = 7'h06;
    localparam logic [6:0] ADDR_MASK1  = 7'h07;
    localparam logic [6:0] ADDR_ID     = 7'h10;
    localparam logic [6:0] ADDR_CTL    = 7'h11;
    localparam logic [6:0] ADDR_MODE0  = 7'h12;
    localparam logic [6:0] ADDR_MODE1  = 7'h13;
    localparam logic [6:0] ADDR_SRESET = 7'h7F;

    localparam logic [7:0] CHIP_ID          = 8'h23;
    localparam int         CTL_P0_PP_BIT    = 4;
    localparam logic [15:0] RST_ALL_ONES    = 16'hFFFF;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [6:0]          reg_addr;
        logic [7:0]          write_data;
        logic [NUM_PINS-1:0] pin_levels;
    } req_t;

    typedef struct packed {
        logic [7:0]          read_data;
        logic [NUM_PINS-1:0] pin_drive;
        logic [NUM_PINS-1:0] pin_enable;
        logic [NUM_PINS-1:0] changed_lines;
        logic                irq_pending;
    } rsp_t;

endpackage

// File: hw/rtl/gpx_stage.sv
// gpx_stage: one valid/ready register slice holding a single item
// depends on nothing beyond the item type handed in

module gpx_stage #(
    parameter type DATA_T = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    output logic  up_ready,
    input  DATA_T up_data,
    output logic  dn_valid,
    input  logic  dn_ready,
    output DATA_T dn_data
);

    logic  valid_reg;
    DATA_T data_reg;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= up_data;
        end
    end

endmodule

// File: hw/rtl/gpx_core.sv
// gpx_core: register file, pin sampling and interrupt state of the expander
// depends on gpx_pkg

module gpx_core
    import gpx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic fire,
    input  req_t req,
    output rsp_t rsp
);

    logic [15:0] last_levels_reg,  last_levels_next;
    logic [15:0] out_latch_reg,    out_latch_next;
    logic [15:0] direction_reg,    direction_next;
    logic [15:0] irq_mask_reg,     irq_mask_next;
    logic [15:0] gpio_mode_reg,    gpio_mode_next;
    logic [7:0]  control_reg,      control_next;
    logic        pending_reg,      pending_next;

    logic [7:0]  rd_data;
    logic [15:0] changed;
    logic [15:0] od_block;
    logic        port_sel;

    always_comb
    begin
        last_levels_next = last_levels_reg;
        out_latch_next   = out_latch_reg;
        direction_next   = direction_reg;
        irq_mask_next    = irq_mask_reg;
        gpio_mode_next   = gpio_mode_reg;
        control_next     = control_reg;
        pending_next     = pending_reg;
        rd_data          = 8'h00;
        changed          = 16'h0000;
        port_sel         = req.reg_addr[0];

        case (req.opcode)
            OP_READ:
            begin
                case (req.reg_addr)
                    ADDR_IN0, ADDR_IN1:
                    begin
                        pending_next = 1'b0;
                        rd_data = port_sel ? last_levels_reg[15:8] : last_levels_reg[7:0];
                    end
                    ADDR_OUT0, ADDR_OUT1:
                        rd_data = port_sel ? out_latch_reg[15:8] : out_latch_reg[7:0];
                    ADDR_DIR0, ADDR_DIR1:
                        rd_data = port_sel ? direction_reg[15:8] : direction_reg[7:0];
                    ADDR_MASK0, ADDR_MASK1:
                        rd_data = port_sel ? irq_mask_reg[15:8] : irq_mask_reg[7:0];
                    ADDR_ID:
                        rd_data = CHIP_ID;
                    ADDR_CTL:
                        rd_data = control_reg;
                    ADDR_MODE0, ADDR_MODE1:
                        rd_data = port_sel ? gpio_mode_reg[15:8] : gpio_mode_reg[7:0];
                    default:
                        rd_data = 8'h00;
                endcase
            end
            OP_WRITE:
            begin
                case (req.reg_addr)
                    ADDR_OUT0:   out_latch_next[7:0]  = req.write_data;
                    ADDR_OUT1:   out_latch_next[15:8] = req.write_data;
                    ADDR_DIR0:   direction_next[7:0]  = req.write_data;
                    ADDR_DIR1:   direction_next[15:8] = req.write_data;
                    ADDR_MASK0:  irq_mask_next[7:0]   = req.write_data;
                    ADDR_MASK1:  irq_mask_next[15:8]  = req.write_data;
                    ADDR_CTL:    control_next         = req.write_data;
                    ADDR_MODE0:  gpio_mode_next[7:0]  = req.write_data;
                    ADDR_MODE1:  gpio_mode_next[15:8] = req.write_data;
                    ADDR_SRESET:
                    begin
                        last_levels_next = 16'h0000;
                        out_latch_next   = 16'h0000;
                        direction_next   = RST_ALL_ONES;
                        irq_mask_next    = RST_ALL_ONES;
                        gpio_mode_next   = RST_ALL_ONES;
                        control_next     = 8'h00;
                        pending_next     = 1'b0;
                    end
                    default: ;
                endcase
            end
            OP_SAMPLE:
            begin
                changed          = (req.pin_levels ^ last_levels_reg) & ~irq_mask_reg
                                   & gpio_mode_reg;
                last_levels_next = req.pin_levels;
                if (changed != 16'h0000)
                begin
                    pending_next = 1'b1;
                end
            end
            default: ;
        endcase

        // open-drain port 0 only drives low
        od_block = control_next[CTL_P0_PP_BIT] ? 16'h0000 : {8'h00, out_latch_next[7:0]};

        rsp.read_data     = rd_data;
        rsp.pin_drive     = out_latch_next;
        rsp.pin_enable    = ~direction_next & gpio_mode_next & ~od_block;
        rsp.changed_lines = changed;
        rsp.irq_pending   = pending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_levels_reg <= 16'h0000;
            out_latch_reg   <= 16'h0000;
            direction_reg   <= RST_ALL_ONES;
            irq_mask_reg    <= RST_ALL_ONES;
            gpio_mode_reg   <= RST_ALL_ONES;
            control_reg     <= 8'h00;
            pending_reg     <= 1'b0;
        end
        else if (fire)
        begin
            last_levels_reg <= last_levels_next;
            out_latch_reg   <= out_latch_next;
            direction_reg   <= direction_next;
            irq_mask_reg    <= irq_mask_next;
            gpio_mode_reg   <= gpio_mode_next;
            control_reg     <= control_next;
            pending_reg     <= pending_next;
        end
    end

endmodule

// File: hw/rtl/gpio_expander_registers.sv
// gpio_expander_registers: top level of the 16-pin register-mapped gpio expander
// depends on gpx_pkg, gpx_stage and gpx_core

// usage
//   req channel (req_valid/req_ready/req) carries one item: a register read,
//   a register write or a sample of the 16 pin levels
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one item per request,
//   in order: read data, output latch, pin enables, changed lines and the
//   interrupt line as they stand after that request
// timing
//   item is captured in an input slice, then the register file updates and the
//   result is captured in an output slice, which drives rsp_valid
//   one item per cycle sustained while rsp_ready is high; the only loop is the
//   read-modify-write of the register file
// stalls
//   when rsp_ready is low the result waits in the output slice, the input
//   slice still takes one more item, then req_ready drops until space frees
//   register state changes only when an item moves into the output slice
// reset
//   rst_n clears both slices and returns the register file to its reset
//   values (all pins inputs, all interrupts masked, gpio mode, port 0 open-drain)
//   a write to the soft reset register does the same to the register file

module gpio_expander_registers
    import gpx_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // input slice towards the register file
    logic s1_valid;
    logic s1_ready;
    req_t s1_req;

    // result from the register file
    rsp_t core_rsp;

    gpx_stage #(
        .DATA_T (req_t)
    ) u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (req_valid),
        .up_ready (req_ready),
        .up_data  (req),
        .dn_valid (s1_valid),
        .dn_ready (s1_ready),
        .dn_data  (s1_req)
    );

    // state commits exactly when the item moves into the result slice
    gpx_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (s1_valid && s1_ready),
        .req   (s1_req),
        .rsp   (core_rsp)
    );

    gpx_stage #(
        .DATA_T (rsp_t)
    ) u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ready (s1_ready),
        .up_data  (core_rsp),
        .dn_valid (rsp_valid),
        .dn_ready (rsp_ready),
        .dn_data  (rsp)
    );

endmodule
